### hdl/multibyte_delimiter_splitter_core_defines.svh
// Assertion macros used by the splitter back end.
// Each macro expects a clk and an arst_n in scope.
`ifndef MULTIBYTE_DELIMITER_SPLITTER_CORE_DEFINES_SVH
`define MULTIBYTE_DELIMITER_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MBDS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define MBDS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mbds_pkg.sv
package mbds_pkg;

	// Largest separator length and derived sizes
	localparam int SEP_MAX     = 8;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 4;
	localparam int SEP_W       = 64;
	localparam int SEP_NBYTES  = (SEP_MAX < SEP_W / BYTE_W) ? SEP_MAX : SEP_W / BYTE_W;
	localparam int EFF_W       = $clog2(SEP_MAX + 1);
	localparam int WIN_DEPTH   = (SEP_MAX > 1) ? SEP_MAX - 1 : 1;
	localparam int FILL_W      = (SEP_MAX > 1) ? $clog2(SEP_MAX) : 1;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES = 1'b1;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_EOT  = 2'd1,
		KIND_EOS  = 2'd2
	} kind_t;

	// One classified input: up to one leading result, a window flush and the end results
	typedef struct packed {
		logic                                first_vld;
		logic                                first_eot;
		logic [BYTE_W-1:0]                   first_byte;
		logic [FILL_W-1:0]                   flush_cnt;
		logic [WIN_DEPTH-1:0][BYTE_W-1:0]    flush;
		logic                                str_end;
		logic                                close;
	} cmd_t;

endpackage

### hdl/mbds_front.sv
module mbds_front (
	input  logic                              clk,
	input  logic                              arst_n,
	// input transfer
	input  logic                              in_vld,
	output logic                              in_rdy,
	input  logic [mbds_pkg::BYTE_W-1:0]       in_byte,
	input  logic                              has_byte,
	input  logic                              string_end,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [mbds_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [mbds_pkg::SEP_W-1:0]        cfg_wdata,
	// command queue write side
	output logic                              q_push,
	output mbds_pkg::cmd_t                    q_data,
	input  logic                              q_full
);
	import mbds_pkg::*;

	logic [LEN_W-1:0]                  sep_len_q;
	logic [SEP_W-1:0]                  sep_bytes_q;
	logic [WIN_DEPTH-1:0][BYTE_W-1:0]  win_q;
	logic [FILL_W-1:0]                 fill_q;
	logic                              tok_q;

	logic [EFF_W-1:0]                  len;
	logic [SEP_MAX-1:0][BYTE_W-1:0]    sep_b;
	logic [SEP_MAX-1:0][BYTE_W-1:0]    cand;
	logic                              hit;
	logic                              full;
	logic                              accept;
	logic [WIN_DEPTH-1:0][BYTE_W-1:0]  win_n;
	logic [FILL_W-1:0]                 fill_n;
	logic                              tok_n;
	cmd_t                              cmd;

	assign in_rdy = !q_full;
	assign accept = in_vld && in_rdy;

	// Effective length, saturated at SEP_MAX
	assign len = (int'(sep_len_q) > SEP_MAX) ? EFF_W'(SEP_MAX) : EFF_W'(sep_len_q);

	// Window plus incoming byte, compared with the separator in parallel
	always_comb begin
		sep_b = '0;
		for (int i = 0; i < SEP_NBYTES; i++) sep_b[i] = sep_bytes_q[BYTE_W*i +: BYTE_W];
		for (int i = 0; i < SEP_MAX; i++) cand[i] = in_byte;
		for (int i = 0; i < WIN_DEPTH; i++)
			if (i < int'(fill_q)) cand[i] = win_q[i];
		hit = 1'b1;
		for (int i = 0; i < SEP_MAX; i++)
			if (i < int'(len) && cand[i] != sep_b[i]) hit = 1'b0;
		full = (EFF_W'(fill_q) + EFF_W'(1)) == len;
	end

	// Classify the transfer and work out the next window state
	always_comb begin
		win_n  = win_q;
		fill_n = fill_q;
		tok_n  = tok_q;
		cmd    = '0;
		if (has_byte) begin
			if (len == '0) begin
				cmd.first_vld  = 1'b1;
				cmd.first_byte = in_byte;
				tok_n          = 1'b1;
			end else if (!full) begin
				for (int i = 0; i < WIN_DEPTH; i++)
					if (i == int'(fill_q)) win_n[i] = in_byte;
				fill_n = fill_q + FILL_W'(1);
			end else if (hit) begin
				fill_n = '0;
				if (tok_q) begin
					cmd.first_vld = 1'b1;
					cmd.first_eot = 1'b1;
					tok_n         = 1'b0;
				end
			end else begin
				// oldest byte can no longer start a match
				cmd.first_vld  = 1'b1;
				cmd.first_byte = cand[0];
				for (int i = 0; i < WIN_DEPTH; i++) win_n[i] = cand[i+1];
				tok_n = 1'b1;
			end
		end
		if (string_end) begin
			cmd.str_end   = 1'b1;
			cmd.flush_cnt = fill_n;
			cmd.flush     = win_n;
			cmd.close     = tok_n || (fill_n != '0) || (len == '0);
			fill_n        = '0;
			tok_n         = 1'b0;
		end
	end

	assign q_push = accept && (cmd.first_vld || cmd.str_end);
	assign q_data = cmd;

	// Configuration and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_len_q   <= '0;
			sep_bytes_q <= '0;
			fill_q      <= '0;
			tok_q       <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_SEP_LEN) begin
				sep_len_q <= cfg_wdata[LEN_W-1:0];
				fill_q    <= '0;
			end else if (cfg_idx == CFG_SEP_BYTES) begin
				sep_bytes_q <= cfg_wdata;
			end
		end else if (accept) begin
			fill_q <= fill_n;
			tok_q  <= tok_n;
		end
	end

	// Window bytes carry no reset
	always_ff @(posedge clk) begin
		if (accept) win_q <= win_n;
	end

endmodule

### hdl/mbds_queue.sv
module mbds_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mbds_pkg::cmd_t   wr_data,
	output logic             full,
	input  logic             pop,
	output logic             rd_vld,
	output mbds_pkg::cmd_t   rd_data
);
	import mbds_pkg::*;

	cmd_t               ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign rd_vld  = cnt_q != '0;
	assign rd_data = ent_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && rd_vld;

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_ptr_q] <= wr_data;
	end

endmodule

### hdl/mbds_back.sv
module mbds_back (
	input  logic                          clk,
	input  logic                          arst_n,
	// command queue read side
	input  logic                          q_vld,
	input  mbds_pkg::cmd_t                q_data,
	output logic                          q_pop,
	// result transfer
	output logic                          out_vld,
	input  logic                          out_rdy,
	output mbds_pkg::kind_t               kind,
	output logic [mbds_pkg::BYTE_W-1:0]   out_byte,
	output logic                          run_last
);
	import mbds_pkg::*;

	`include "multibyte_delimiter_splitter_core_defines.svh"

	cmd_t  cur_q;
	logic  cur_vld_q;
	cmd_t  cur_n;
	logic  fire;
	logic  take;

	// Pick the next result of the current command and what remains after it
	always_comb begin
		cur_n    = cur_q;
		kind     = KIND_EOS;
		out_byte = '0;
		if (cur_q.first_vld) begin
			kind            = cur_q.first_eot ? KIND_EOT : KIND_DATA;
			out_byte        = cur_q.first_eot ? '0 : cur_q.first_byte;
			cur_n.first_vld = 1'b0;
		end else if (cur_q.flush_cnt != '0) begin
			kind     = KIND_DATA;
			out_byte = cur_q.flush[0];
			for (int i = 0; i < WIN_DEPTH - 1; i++) cur_n.flush[i] = cur_q.flush[i+1];
			cur_n.flush_cnt = cur_q.flush_cnt - FILL_W'(1);
		end else if (cur_q.close) begin
			kind        = KIND_EOT;
			cur_n.close = 1'b0;
		end else begin
			cur_n.str_end = 1'b0;
		end
		run_last = !(cur_n.first_vld || cur_n.flush_cnt != '0 || cur_n.close || cur_n.str_end);
	end

	assign out_vld = cur_vld_q;
	assign fire    = out_vld && out_rdy;
	assign take    = !cur_vld_q || (fire && run_last);
	assign q_pop   = take && q_vld;

	// Command being expanded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
		end else if (take) begin
			cur_vld_q <= q_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take)      cur_q <= q_data;
		else if (fire) cur_q <= cur_n;
	end

	`MBDS_ASSERT_IMP(a_cmd_nonempty, cur_vld_q,
		cur_q.first_vld || cur_q.flush_cnt != '0 || cur_q.close || cur_q.str_end,
		"held command has no result left")
	`MBDS_ASSERT_IMP(a_close_with_end, cur_vld_q && cur_q.close, cur_q.str_end,
		"token close pending without string end")
	`MBDS_ASSERT_IMP(a_eos_is_last, cur_vld_q && kind == KIND_EOS, run_last,
		"end of string is not the last result of its input")
	`MBDS_ASSERT_NXT(a_drain_idle, fire && run_last && !q_vld, !cur_vld_q,
		"result side still valid after draining an empty queue")

endmodule

### hdl/multibyte_delimiter_splitter_core.sv
// Multibyte delimiter splitter. Splits a byte stream into tokens at a configured separator of
// up to 8 bytes (leftmost-first, non-overlapping; empty tokens dropped); with separator length
// zero the whole string is one token. One input transfer is taken per cycle while the 4-entry
// command queue has room. Each input yields 0 to fill+3 results (at most 10), delivered one per
// cycle while the result side accepts them; the queue absorbs those bursts and only a full
// queue holds the input side. Registers must be written only while the block is idle; the
// block itself does not enforce this. A write of the separator length discards bytes still
// held in the look-behind window. No clearing pass follows reset.
module multibyte_delimiter_splitter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] in_byte
	input  logic [0:0]                        s_tuser,   // [0] has_byte
	input  logic                              s_tlast,   // string_end
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // [7:0] out_byte
	output logic [1:0]                        m_tuser,   // [1:0] kind
	output logic                              m_tlast,   // run_last
	// configuration
	input  logic                              cfg_we,
	input  logic [mbds_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [mbds_pkg::SEP_W-1:0]        cfg_wdata
);
	import mbds_pkg::*;

	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_vld;
	cmd_t   q_wr;
	cmd_t   q_rd;
	kind_t  kind;

	// Front: window compare and classification
	mbds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (s_tvalid),
		.in_rdy     (s_tready),
		.in_byte    (s_tdata),
		.has_byte   (s_tuser[0]),
		.string_end (s_tlast),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.q_push     (q_push),
		.q_data     (q_wr),
		.q_full     (q_full)
	);

	// Command queue
	mbds_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.rd_vld  (q_vld),
		.rd_data (q_rd)
	);

	// Back: result sequencing
	mbds_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_vld    (q_vld),
		.q_data   (q_rd),
		.q_pop    (q_pop),
		.out_vld  (m_tvalid),
		.out_rdy  (m_tready),
		.kind     (kind),
		.out_byte (m_tdata),
		.run_last (m_tlast)
	);

	assign m_tuser = kind;

endmodule
